// ===== design/mxw_pkg.sv =====
// ----------------------------------------------------------------------------
// mxw_pkg
// Shared types and constants of the mesh XY wormhole switch arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package mxw_pkg;

    localparam int MXW_NPORTS     = 5;
    localparam int MXW_ID_W       = 4;
    localparam int MXW_ROUTE_W    = 3;
    localparam int MXW_MESH_WIDTH = 4;

    localparam logic [MXW_ROUTE_W-1:0] ROUTE_NONE  = 3'd0;
    localparam logic [MXW_ROUTE_W-1:0] ROUTE_LOCAL = 3'd1;
    localparam logic [MXW_ROUTE_W-1:0] ROUTE_NORTH = 3'd2;
    localparam logic [MXW_ROUTE_W-1:0] ROUTE_EAST  = 3'd3;
    localparam logic [MXW_ROUTE_W-1:0] ROUTE_SOUTH = 3'd4;
    localparam logic [MXW_ROUTE_W-1:0] ROUTE_WEST  = 3'd5;

    typedef logic [MXW_NPORTS-1:0]  t_port_mask;
    typedef logic [MXW_ROUTE_W-1:0] t_route;
    typedef logic [MXW_ID_W-1:0]    t_id;

    typedef struct packed {
        logic [MXW_NPORTS*MXW_ID_W-1:0] req_dests;
        t_port_mask                     req_empty;
        t_port_mask                     req_tail;
        t_port_mask                     out_busy;
    } t_req;

    typedef struct packed {
        t_port_mask                        grants;
        logic [MXW_NPORTS*MXW_ROUTE_W-1:0] selects;
    } t_res;

    // Output mask of a route code; codes without an output map to nothing.
    function automatic t_port_mask out_onehot(input t_route route);
        t_port_mask m;
        m = '0;
        case (route)
            ROUTE_LOCAL: m = 5'b00001;
            ROUTE_NORTH: m = 5'b00010;
            ROUTE_EAST:  m = 5'b00100;
            ROUTE_SOUTH: m = 5'b01000;
            ROUTE_WEST:  m = 5'b10000;
            default:     m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== design/mesh_xy_wormhole_switch_arbiter_core.sv =====
// ----------------------------------------------------------------------------
// mesh_xy_wormhole_switch_arbiter_core
// Switch arbiter of one five-port XY-routed wormhole mesh router.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one request
//   word per router cycle: destinations, empty flags, tail flags and busy
//   outputs. Output channel (o_out_valid / i_out_ready / o_out_data) returns
//   one grant word per request word: grant bits and route selects.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the router
//   id; always ready; the user writes it only while idle, not enforced here.
// Flow: an accepted word waits in the input register and is allocated as it
//   moves into the result register, where its grant word is shown valid.
// Throughput: one word per cycle unless stalled; allocation is a single pass
//   through five priority-chained steps between input and result registers.
// Reset: clears the router id, all connections and output reservations, and
//   the valid flags of both pipeline registers.
// Stall: when the receiver holds i_out_ready low the result register holds
//   and the input register holds behind it; allocation state advances only
//   when a word moves into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_xy_wormhole_switch_arbiter_core
    import mxw_pkg::*;
#(
    parameter int MESH_WIDTH = MXW_MESH_WIDTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire t_req  i_in_data,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_res       o_out_data,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire t_id   i_cfg_data
);

    t_id  r_node_id;
    logic r_in_valid;
    t_req r_in;
    logic r_out_valid;
    t_res r_out;
    t_res n_out;
    logic advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    mxw_arb #(.MESH_WIDTH(MESH_WIDTH)) u_arb (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (advance),
        .i_node_id (r_node_id),
        .i_req     (r_in),
        .o_res     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id   <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_node_id <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: load on handshake, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ===== design/mxw_route.sv =====
// ----------------------------------------------------------------------------
// mxw_route
// XY route of one destination id: column first, then row.
// ----------------------------------------------------------------------------
`default_nettype none

module mxw_route
    import mxw_pkg::*;
#(
    parameter int MESH_WIDTH = MXW_MESH_WIDTH
) (
    input  wire t_id    i_here,
    input  wire t_id    i_dest,
    output t_route      o_route
);

    localparam int IdMax = (1 << MXW_ID_W) - 1;
    localparam int RowW  = $clog2(IdMax / MESH_WIDTH + 1);
    localparam int ColW  = (MESH_WIDTH > 2) ? $clog2(MESH_WIDTH) : 1;

    // row and column of an id, looked up over every id value
    function automatic logic [RowW-1:0] row_of(input t_id id);
        logic [RowW-1:0] row;
        row = '0;
        for (int i = 0; i <= IdMax; i++) begin
            if (id == t_id'(i)) begin
                row = RowW'(i / MESH_WIDTH);
            end
        end
        return row;
    endfunction

    function automatic logic [ColW-1:0] col_of(input t_id id);
        logic [ColW-1:0] col;
        col = '0;
        for (int i = 0; i <= IdMax; i++) begin
            if (id == t_id'(i)) begin
                col = ColW'(i % MESH_WIDTH);
            end
        end
        return col;
    endfunction

    logic [RowW-1:0] here_row, tgt_row;
    logic [ColW-1:0] here_col, tgt_col;

    assign here_row = row_of(i_here);
    assign tgt_row  = row_of(i_dest);
    assign here_col = col_of(i_here);
    assign tgt_col  = col_of(i_dest);

    always_comb begin
        if (tgt_col > here_col) begin
            o_route = ROUTE_EAST;
        end else if (tgt_col < here_col) begin
            o_route = ROUTE_WEST;
        end else if (tgt_row > here_row) begin
            o_route = ROUTE_SOUTH;
        end else if (tgt_row < here_row) begin
            o_route = ROUTE_NORTH;
        end else begin
            o_route = ROUTE_LOCAL;
        end
    end

endmodule

`default_nettype wire

// ===== design/mxw_arb.sv =====
// ----------------------------------------------------------------------------
// mxw_arb
// Fixed-priority switch allocation with wormhole connection state.
// ----------------------------------------------------------------------------
`default_nettype none

module mxw_arb
    import mxw_pkg::*;
#(
    parameter int MESH_WIDTH = MXW_MESH_WIDTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_fire,
    input  wire t_id   i_node_id,
    input  wire t_req  i_req,
    output t_res       o_res
);

    t_route     fresh [MXW_NPORTS];
    logic       r_conn [MXW_NPORTS];
    logic       n_conn [MXW_NPORTS];
    t_route     r_held [MXW_NPORTS];
    t_route     n_held [MXW_NPORTS];
    t_port_mask r_resv, n_resv;

    for (genvar k = 0; k < MXW_NPORTS; k++) begin : g_route
        mxw_route #(.MESH_WIDTH(MESH_WIDTH)) u_route (
            .i_here  (i_node_id),
            .i_dest  (i_req.req_dests[k*MXW_ID_W +: MXW_ID_W]),
            .o_route (fresh[k])
        );
    end

    always_comb begin
        t_port_mask free_set;
        t_port_mask hit;
        t_route     route;
        logic       granted;
        free_set = ~i_req.out_busy;
        n_resv   = r_resv;
        o_res    = '0;
        for (int k = 0; k < MXW_NPORTS; k++) begin
            n_conn[k] = r_conn[k];
            n_held[k] = r_held[k];
            route     = r_conn[k] ? r_held[k] : fresh[k];
            hit       = out_onehot(route) & free_set;
            // a new packet may not take an output that another packet holds
            granted   = !i_req.req_empty[k] && (|hit)
                        && !(!r_conn[k] && (|(hit & r_resv)));
            if (!i_req.req_empty[k] && !r_conn[k]) begin
                n_held[k] = fresh[k];
            end
            if (granted) begin
                o_res.grants[k]                         = 1'b1;
                o_res.selects[k*MXW_ROUTE_W +: MXW_ROUTE_W] = route;
                free_set  = free_set & ~hit;
                n_conn[k] = !i_req.req_tail[k];
                n_resv    = i_req.req_tail[k] ? (n_resv & ~hit) : (n_resv | hit);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resv <= '0;
            for (int k = 0; k < MXW_NPORTS; k++) begin
                r_conn[k] <= 1'b0;
                r_held[k] <= ROUTE_NONE;
            end
        end else if (i_fire) begin
            r_resv <= n_resv;
            for (int k = 0; k < MXW_NPORTS; k++) begin
                r_conn[k] <= n_conn[k];
                r_held[k] <= n_held[k];
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/mxw_checker.sv =====
// ----------------------------------------------------------------------------
// mxw_checker
// Port-level checks of the switch arbiter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mxw_checker
    import mxw_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire t_res  o_out_data
);

    logic sel_match;
    logic dup_output;

    // a grant bit goes with a real route code, no grant with code zero
    always_comb begin
        t_route r;
        sel_match = 1'b1;
        for (int k = 0; k < MXW_NPORTS; k++) begin
            r = o_out_data.selects[k*MXW_ROUTE_W +: MXW_ROUTE_W];
            if (o_out_data.grants[k] != (out_onehot(r) != '0)) begin
                sel_match = 1'b0;
            end
            if (!o_out_data.grants[k] && r != ROUTE_NONE) begin
                sel_match = 1'b0;
            end
        end
    end

    // no two granted inputs share one output
    always_comb begin
        t_port_mask seen;
        t_port_mask m;
        seen       = '0;
        dup_output = 1'b0;
        for (int k = 0; k < MXW_NPORTS; k++) begin
            m = o_out_data.grants[k]
                ? out_onehot(o_out_data.selects[k*MXW_ROUTE_W +: MXW_ROUTE_W]) : '0;
            if ((seen & m) != '0) begin
                dup_output = 1'b1;
            end
            seen = seen | m;
        end
    end

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result word changed");

    a_grant_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> sel_match)
        else $error("grant bits and route selects disagree");

    a_one_per_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !dup_output)
        else $error("one output granted to two inputs");

endmodule

bind mesh_xy_wormhole_switch_arbiter_core mxw_checker u_mxw_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the mesh XY wormhole switch arbiter core.
// Request words are sent with random gaps and random output stalls. Each one
// is run through a behavioral arbiter that keeps its own connections, held
// routes and reservations, and each grant word from the core is compared with
// the oldest pending prediction.
// ----------------------------------------------------------------------------

module tb;
    import mxw_pkg::*;

    // Predicts grant words and checks them against the core's output.
    class grant_scoreboard;
        t_id    node_id;
        bit     connected [MXW_NPORTS];
        t_route held      [MXW_NPORTS];
        bit     reserved  [MXW_NPORTS];
        t_res   grant_queue [$];
        int     errors;

        function new();
            node_id = '0;
            errors  = 0;
            foreach (connected[k]) begin
                connected[k] = 1'b0;
                held[k]      = ROUTE_NONE;
                reserved[k]  = 1'b0;
            end
        endfunction

        function int pending();
            return grant_queue.size();
        endfunction

        // Column first, then row; ids are split without any range check.
        function t_route next_hop(t_id dest);
            int here_row, here_col, tgt_row, tgt_col;
            here_row = node_id / MXW_MESH_WIDTH;
            here_col = node_id % MXW_MESH_WIDTH;
            tgt_row  = dest / MXW_MESH_WIDTH;
            tgt_col  = dest % MXW_MESH_WIDTH;
            if (tgt_col > here_col) return ROUTE_EAST;
            if (tgt_col < here_col) return ROUTE_WEST;
            if (tgt_row > here_row) return ROUTE_SOUTH;
            if (tgt_row < here_row) return ROUTE_NORTH;
            return ROUTE_LOCAL;
        endfunction

        function t_port_mask output_of(t_route route);
            if (route >= ROUTE_LOCAL && route <= ROUTE_WEST)
                return t_port_mask'(1) << (int'(route) - 1);
            return '0;
        endfunction

        function t_res arbitrate(t_req req);
            t_res       res;
            t_port_mask free_outs;
            t_port_mask hit;
            t_route     route;
            int         slot;
            res       = '0;
            free_outs = ~req.out_busy;
            for (int k = 0; k < MXW_NPORTS; k++) begin
                if (req.req_empty[k]) continue;
                // an unconnected input keeps its fresh route even when refused
                if (!connected[k])
                    held[k] = next_hop(req.req_dests[MXW_ID_W*k +: MXW_ID_W]);
                route = held[k];
                hit   = output_of(route) & free_outs;
                slot  = int'(route) - 1;
                if (!connected[k] && hit != '0 && reserved[slot])
                    hit = '0;
                if (hit != '0) begin
                    res.grants[k] = 1'b1;
                    res.selects[MXW_ROUTE_W*k +: MXW_ROUTE_W] = route;
                    free_outs &= ~hit;
                    connected[k]   = !req.req_tail[k];
                    reserved[slot] = !req.req_tail[k];
                end
            end
            return res;
        endfunction

        function void note_request(t_req req);
            grant_queue.push_back(arbitrate(req));
        endfunction

        task report(string what, logic [14:0] got, logic [14:0] want);
            if (errors < 100)
                $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got,
                         want);
            errors++;
        endtask

        task check_grant(t_res got);
            t_res want;
            if (grant_queue.size() == 0) begin
                report("grant word with none pending", 15'(got), '0);
                return;
            end
            want = grant_queue.pop_front();
            if (got.grants !== want.grants)
                report("grants", 15'(got.grants), 15'(want.grants));
            if (got.selects !== want.selects)
                report("selects", got.selects, want.selects);
        endtask
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_req       in_data   = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    t_id        cfg_data  = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_res       o_out_data;
    logic       o_cfg_ready;

    int         stall_pct  = 0;
    int         stall_left = 0;

    grant_scoreboard sb = new();

    mesh_xy_wormhole_switch_arbiter_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: stall in bursts of random length.
    always @(posedge clk) begin
        if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && o_in_ready)
                sb.note_request(in_data);
            if (o_out_valid && out_ready)
                sb.check_grant(o_out_data);
        end
    end

    function automatic logic [19:0] dest_word(t_id d0, t_id d1, t_id d2, t_id d3, t_id d4);
        return {d4, d3, d2, d1, d0};
    endfunction

    function automatic t_req random_req(int empty_pct, int tail_pct, int busy_pct);
        t_req req;
        req.req_dests = 20'($urandom);
        for (int k = 0; k < MXW_NPORTS; k++) begin
            req.req_empty[k] = $urandom_range(0, 99) < empty_pct;
            req.req_tail[k]  = $urandom_range(0, 99) < tail_pct;
            req.out_busy[k]  = $urandom_range(0, 99) < busy_pct;
        end
        return req;
    endfunction

    // Hold the word until it is taken.
    task automatic send_req(t_req req);
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!o_in_ready);
    endtask

    task automatic sender_gap(int idle_pct);
        if ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every predicted grant word has come back.
    task automatic drain_grants();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_node_id(t_id id);
        cfg_valid <= 1'b1;
        cfg_data  <= id;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid  <= 1'b0;
        sb.node_id = id;
    endtask

    // Router 5 sits at row 1, column 1, so every route code is reachable.
    task automatic directed_words();
        send_req({dest_word(0, 0, 0, 0, 0), 5'h1F, 5'h00, 5'h00});
        send_req({20'hFFFFF, 5'h1F, 5'h1F, 5'h1F});
        send_req({dest_word(5, 1, 6, 9, 4), 5'h00, 5'h1F, 5'h00});
        send_req({dest_word(5, 1, 6, 9, 4), 5'h00, 5'h1F, 5'h1F});
        // input 0 opens a packet east, the others contend for east
        send_req({dest_word(15, 15, 15, 15, 15), 5'h00, 5'h00, 5'h00});
        send_req({dest_word(0, 7, 3, 11, 15), 5'h01, 5'h00, 5'h00});
        send_req({dest_word(0, 0, 0, 0, 0), 5'h1E, 5'h00, 5'h04});
        send_req({dest_word(0, 0, 0, 0, 0), 5'h1E, 5'h01, 5'h00});
        send_req({dest_word(4, 0, 12, 8, 13), 5'h00, 5'h00, 5'h00});
        send_req({dest_word(4, 0, 12, 8, 13), 5'h00, 5'h11, 5'h00});
        send_req({dest_word(1, 2, 3, 0, 5), 5'h00, 5'h00, 5'h0A});
        send_req({dest_word(5, 5, 5, 5, 5), 5'h00, 5'h1F, 5'h00});
        send_req({dest_word(5, 5, 5, 5, 5), 5'h0F, 5'h10, 5'h00});
        for (int j = 0; j < MXW_NPORTS; j++)
            send_req({dest_word(5, 1, 6, 9, 4), 5'h00, 5'h1F, t_port_mask'(1) << j});
        send_req({dest_word(15, 0, 15, 0, 10), 5'h00, 5'h1F, 5'h00});
        send_req({dest_word(15, 15, 15, 15, 15), 5'h00, 5'h00, 5'h1B});
    endtask

    task automatic random_phase(t_id id, int words, int empty_pct, int tail_pct,
                                int busy_pct, int idle_pct, int stalls, int pause_at);
        drain_grants();
        write_node_id(id);
        stall_pct = stalls;
        for (int i = 0; i < words; i++) begin
            if (i == pause_at)
                drain_grants();
            sender_gap(idle_pct);
            send_req(random_req(empty_pct, tail_pct, busy_pct));
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        write_node_id(4'd5);
        stall_pct = 20;
        directed_words();
        random_phase(4'd15, 300, 20, 30, 20, 10, 10, -1);
        random_phase(4'd0, 300, 5, 10, 50, 0, 30, 150);
        random_phase(t_id'($urandom), 300, 60, 50, 5, 30, 0, -1);
        random_phase(4'd10, 300, 50, 50, 50, 15, 15, -1);
        random_phase(t_id'($urandom), 300, 20, 25, 25, 10, 10, -1);
        random_phase(4'd5, 330, 20, 30, 20, 0, 0, -1);
        drain_grants();
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
